// File: rtl/core/ssprk54_stage_update_core_assert.svh
`ifndef SSPRK54_STAGE_UPDATE_CORE_ASSERT_SVH
`define SSPRK54_STAGE_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SSPRK54_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssprk54 core check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define SSPRK54_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssprk54 core check failed");

`endif

// File: rtl/core/ssprk54_pkg.sv
package ssprk54_pkg;

    localparam int DOF_COUNT = 4096;
    localparam int DOF_W     = $clog2(DOF_COUNT);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_SAVE    = 2'd1;
    localparam logic [1:0] ACT_RESTORE = 2'd2;
    localparam logic [1:0] ACT_STAGE   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_STAGE = 2'd1;
    localparam logic [1:0] STATUS_ZERO_MASS = 2'd2;
    localparam logic [1:0] STATUS_SAT       = 2'd3;

    localparam logic [2:0] STAGE_0    = 3'd0;
    localparam logic [2:0] STAGE_1    = 3'd1;
    localparam logic [2:0] STAGE_2    = 3'd2;
    localparam logic [2:0] STAGE_3    = 3'd3;
    localparam logic [2:0] STAGE_LAST = 3'd4;

    localparam longint unsigned FIVE15 = 64'd30517578125;
    localparam longint unsigned HALF15 = FIVE15 / 64'd2;
    localparam longint unsigned SCALE  = 64'd32768;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    localparam logic signed [31:0] K_S0_R = 32'((64'd391752226571890 / FIVE15) * SCALE
        + (((64'd391752226571890 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S1_U0 = 32'((64'd444370493651235 / FIVE15) * SCALE
        + (((64'd444370493651235 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S1_U1 = 32'((64'd555629506348765 / FIVE15) * SCALE
        + (((64'd555629506348765 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S1_R = 32'((64'd368410593050371 / FIVE15) * SCALE
        + (((64'd368410593050371 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S2_U0 = 32'((64'd620101851488403 / FIVE15) * SCALE
        + (((64'd620101851488403 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S2_U2 = 32'((64'd379898148511597 / FIVE15) * SCALE
        + (((64'd379898148511597 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S2_R = 32'((64'd251891774247377 / FIVE15) * SCALE
        + (((64'd251891774247377 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S3_U0 = 32'((64'd178079954393132 / FIVE15) * SCALE
        + (((64'd178079954393132 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S3_U3 = 32'((64'd821920045606868 / FIVE15) * SCALE
        + (((64'd821920045606868 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S3_R = 32'((64'd544974750228521 / FIVE15) * SCALE
        + (((64'd544974750228521 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S4_U2 = 32'((64'd517231671970585 / FIVE15) * SCALE
        + (((64'd517231671970585 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S4_U3 = 32'((64'd96059710526147 / FIVE15) * SCALE
        + (((64'd96059710526147 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S4_R3 = 32'((64'd63692468666290 / FIVE15) * SCALE
        + (((64'd63692468666290 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S4_U4 = 32'((64'd386708617503269 / FIVE15) * SCALE
        + (((64'd386708617503269 % FIVE15) * SCALE) + HALF15) / FIVE15);
    localparam logic signed [31:0] K_S4_R4 = 32'((64'd226007483236906 / FIVE15) * SCALE
        + (((64'd226007483236906 % FIVE15) * SCALE) + HALF15) / FIVE15);

    typedef struct packed {
        logic        [1:0]  action;
        logic        [2:0]  stage;
        logic        [11:0] dof_index;
        logic signed [31:0] load_value;
        logic signed [31:0] residual;
        logic        [31:0] mass_diag;
    } req_t;

    typedef struct packed {
        logic        [11:0] out_index;
        logic signed [31:0] current_out;
        logic        [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic        [1:0]       action;
        logic        [2:0]       stage;
        logic        [DOF_W-1:0] idx;
        logic signed [31:0]      load_value;
        logic                    mass_zero;
    } item_t;

    typedef struct packed {
        logic signed [31:0] cur;
        logic signed [31:0] old;
        logic signed [31:0] w1;
        logic signed [31:0] w2;
        logic signed [31:0] w3;
        logic signed [31:0] w4;
        logic signed [31:0] s3;
    } row_t;

endpackage

// File: rtl/core/ssprk54_stage_update_core.sv
// Channel   | Signals                        | Direction | Content
// ----------+--------------------------------+-----------+------------------------------
// request   | req_valid, req_ready, req      | in        | action, stage, dof, operands
// response  | rsp_valid, rsp_ready, rsp      | out       | dof, current value, status
// time step | time_step_wr_en/_wr_data       | in        | dt, written while idle
//
// One request is taken per cycle unless a dof hazard or a stalled response holds req_ready low.
// The scaled residual goes through one 32x32 multiplier and a 32-stage restoring divider.
// The per-dof state is one 224-bit row memory, read into rd_row_reg, carried through e2 and e3
// and written back updated from e3; a request to a dof still in e1, e2 or e3 waits at the divider output.
// Reset clears the pipeline valid bits and the time step; the row memory is not cleared.
// A stalled response holds the whole pipeline and drops req_ready.
module ssprk54_stage_update_core
    import ssprk54_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        time_step_wr_en,
    input  logic [31:0] time_step_wr_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    localparam int DIV_STEPS = 32;

    logic [31:0] time_step_reg;

    logic adv;
    logic front_adv;
    logic hazard;

    logic        a_valid_reg;
    req_t        a_req_reg;

    logic        b_valid_reg;
    item_t       b_item_reg;
    logic [63:0] b_prod_reg;
    logic        b_neg_reg;
    logic [31:0] b_mass_reg;

    logic        c_valid_reg;
    item_t       c_item_reg;
    logic        c_neg_reg;
    logic        c_ovf_reg;
    logic [31:0] c_mass_reg;
    logic [31:0] c_rem_reg;
    logic [31:0] c_low_reg;

    logic        d_valid_reg [DIV_STEPS];
    item_t       d_item_reg  [DIV_STEPS];
    logic        d_neg_reg   [DIV_STEPS];
    logic        d_ovf_reg   [DIV_STEPS];
    logic [31:0] d_mass_reg  [DIV_STEPS];
    logic [31:0] d_rem_reg   [DIV_STEPS];
    logic [31:0] d_low_reg   [DIV_STEPS];
    logic [31:0] d_quo_reg   [DIV_STEPS];

    logic [31:0] d_rem_next  [DIV_STEPS];
    logic [31:0] d_low_next  [DIV_STEPS];
    logic [31:0] d_quo_next  [DIV_STEPS];

    logic               s_sat;
    logic signed [31:0] s_val;

    row_t mem [DOF_COUNT];
    row_t rd_row_reg;
    logic wr_en;
    logic rd_en;
    logic [DOF_W-1:0] wr_idx;
    logic [DOF_W-1:0] rd_idx;

    logic               e1_valid_reg;
    item_t              e1_item_reg;
    logic signed [31:0] e1_s_reg;
    logic               e1_sflag_reg;

    logic signed [31:0] co [5];
    logic signed [31:0] vo [5];

    logic               e2_valid_reg;
    item_t              e2_item_reg;
    logic signed [31:0] e2_s_reg;
    logic               e2_sflag_reg;
    row_t               e2_row_reg;
    logic signed [63:0] e2_prod_reg [5];

    logic               e3_valid_reg;
    item_t              e3_item_reg;
    logic signed [31:0] e3_s_reg;
    logic               e3_sflag_reg;
    row_t               e3_row_reg;
    logic signed [63:0] e3_sum_reg;

    logic               e3_upd_ok;
    logic [63:0]        sum_mag;
    logic [63:0]        sum_rnd;
    logic [33:0]        res_mag;
    logic               res_sat;
    logic signed [31:0] res_val;
    row_t               new_row;
    logic [1:0]         new_status;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign front_adv = adv && !hazard;
    assign req_ready = front_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= '0;
        end
        else if (time_step_wr_en)
        begin
            time_step_reg <= time_step_wr_data;
        end
    end

    // Front pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else if (front_adv)
        begin
            a_valid_reg    <= req_valid;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
        end
    end

    // The restoring divider brings in one dividend bit per stage.
    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            logic [31:0] rem_in;
            logic [31:0] low_in;
            logic [31:0] quo_in;
            logic [31:0] mass_in;
            logic [32:0] trial;
            logic        ge;
            if (k == 0)
            begin
                rem_in  = c_rem_reg;
                low_in  = c_low_reg;
                quo_in  = '0;
                mass_in = c_mass_reg;
            end
            else
            begin
                rem_in  = d_rem_reg[k-1];
                low_in  = d_low_reg[k-1];
                quo_in  = d_quo_reg[k-1];
                mass_in = d_mass_reg[k-1];
            end
            trial         = {rem_in, low_in[31]};
            ge            = trial >= {1'b0, mass_in};
            d_rem_next[k] = ge ? 32'(trial - {1'b0, mass_in}) : trial[31:0];
            d_low_next[k] = {low_in[30:0], 1'b0};
            d_quo_next[k] = {quo_in[30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            logic [64:0] num;
            a_req_reg <= req;

            b_item_reg.action     <= a_req_reg.action;
            b_item_reg.stage      <= a_req_reg.stage;
            b_item_reg.idx        <= a_req_reg.dof_index[DOF_W-1:0];
            b_item_reg.load_value <= a_req_reg.load_value;
            b_item_reg.mass_zero  <= a_req_reg.mass_diag == '0;
            b_neg_reg             <= a_req_reg.residual[31];
            b_mass_reg            <= a_req_reg.mass_diag;
            b_prod_reg            <= {32'b0, (a_req_reg.residual[31]
                                      ? 32'(-a_req_reg.residual)
                                      : 32'(a_req_reg.residual))} * {32'b0, time_step_reg};

            num        = {1'b0, b_prod_reg} + {34'b0, b_mass_reg[31:1]};
            c_item_reg <= b_item_reg;
            c_neg_reg  <= b_neg_reg;
            c_mass_reg <= b_mass_reg;
            c_ovf_reg  <= num[64:32] >= {1'b0, b_mass_reg};
            c_rem_reg  <= num[63:32];
            c_low_reg  <= num[31:0];

            d_item_reg[0] <= c_item_reg;
            d_neg_reg[0]  <= c_neg_reg;
            d_ovf_reg[0]  <= c_ovf_reg;
            d_mass_reg[0] <= c_mass_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                d_item_reg[k] <= d_item_reg[k-1];
                d_neg_reg[k]  <= d_neg_reg[k-1];
                d_ovf_reg[k]  <= d_ovf_reg[k-1];
                d_mass_reg[k] <= d_mass_reg[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                d_rem_reg[k] <= d_rem_next[k];
                d_low_reg[k] <= d_low_next[k];
                d_quo_reg[k] <= d_quo_next[k];
            end
        end
    end

    always_comb
    begin
        logic [31:0] q;
        q = d_quo_reg[DIV_STEPS-1];
        if (d_neg_reg[DIV_STEPS-1])
        begin
            s_sat = d_ovf_reg[DIV_STEPS-1] || q > 32'h8000_0000;
            s_val = s_sat ? 32'sh8000_0000 : $signed(32'(-q));
        end
        else
        begin
            s_sat = d_ovf_reg[DIV_STEPS-1] || q > 32'h7FFF_FFFF;
            s_val = s_sat ? 32'sh7FFF_FFFF : $signed(q);
        end
    end

    assign rd_idx = d_item_reg[DIV_STEPS-1].idx;
    assign hazard = d_valid_reg[DIV_STEPS-1]
                 && ((e1_valid_reg && e1_item_reg.idx == rd_idx)
                  || (e2_valid_reg && e2_item_reg.idx == rd_idx)
                  || (e3_valid_reg && e3_item_reg.idx == rd_idx));
    assign rd_en  = adv;
    assign wr_en  = adv && e3_valid_reg;
    assign wr_idx = e3_item_reg.idx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= new_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg  <= d_valid_reg[DIV_STEPS-1] && !hazard;
            e2_valid_reg  <= e1_valid_reg;
            e3_valid_reg  <= e2_valid_reg;
            rsp_valid_reg <= e3_valid_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            co[k] = '0;
            vo[k] = '0;
        end
        vo[2] = e1_s_reg;
        case (e1_item_reg.stage)
            STAGE_0:
            begin
                co[0] = ONE_Q30;  vo[0] = rd_row_reg.old;
                co[2] = K_S0_R;
            end
            STAGE_1:
            begin
                co[0] = K_S1_U0;  vo[0] = rd_row_reg.old;
                co[1] = K_S1_U1;  vo[1] = rd_row_reg.w1;
                co[2] = K_S1_R;
            end
            STAGE_2:
            begin
                co[0] = K_S2_U0;  vo[0] = rd_row_reg.old;
                co[1] = K_S2_U2;  vo[1] = rd_row_reg.w2;
                co[2] = K_S2_R;
            end
            STAGE_3:
            begin
                co[0] = K_S3_U0;  vo[0] = rd_row_reg.old;
                co[1] = K_S3_U3;  vo[1] = rd_row_reg.w3;
                co[2] = K_S3_R;
            end
            STAGE_LAST:
            begin
                co[0] = K_S4_U2;  vo[0] = rd_row_reg.w2;
                co[1] = K_S4_U3;  vo[1] = rd_row_reg.w3;
                co[2] = K_S4_R4;
                co[3] = K_S4_R3;  vo[3] = rd_row_reg.s3;
                co[4] = K_S4_U4;  vo[4] = rd_row_reg.w4;
            end
            default:
            begin
                co[2] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_item_reg  <= d_item_reg[DIV_STEPS-1];
            e1_s_reg     <= s_val;
            e1_sflag_reg <= s_sat;

            e2_item_reg  <= e1_item_reg;
            e2_s_reg     <= e1_s_reg;
            e2_sflag_reg <= e1_sflag_reg;
            e2_row_reg   <= rd_row_reg;
            for (int k = 0; k < 5; k++)
            begin
                e2_prod_reg[k] <= 64'(co[k]) * 64'(vo[k]);
            end

            e3_item_reg  <= e2_item_reg;
            e3_s_reg     <= e2_s_reg;
            e3_sflag_reg <= e2_sflag_reg;
            e3_row_reg   <= e2_row_reg;
            e3_sum_reg   <= e2_prod_reg[0] + e2_prod_reg[1] + e2_prod_reg[2]
                          + e2_prod_reg[3] + e2_prod_reg[4];

            rsp_reg.out_index   <= 12'(e3_item_reg.idx);
            rsp_reg.current_out <= new_row.cur;
            rsp_reg.status      <= new_status;
        end
    end

    assign e3_upd_ok = e3_item_reg.stage <= STAGE_LAST && !e3_item_reg.mass_zero;

    always_comb
    begin
        sum_mag = e3_sum_reg[63] ? 64'(-e3_sum_reg) : 64'(e3_sum_reg);
        sum_rnd = sum_mag + (64'd1 << 29);
        res_mag = sum_rnd[63:30];
        if (e3_sum_reg[63])
        begin
            res_sat = res_mag > 34'h0_8000_0000;
            res_val = res_sat ? 32'sh8000_0000 : $signed(32'(-res_mag));
        end
        else
        begin
            res_sat = res_mag > 34'h0_7FFF_FFFF;
            res_val = res_sat ? 32'sh7FFF_FFFF : $signed(res_mag[31:0]);
        end
    end

    always_comb
    begin
        new_row    = e3_row_reg;
        new_status = STATUS_OK;
        unique case (e3_item_reg.action)
            ACT_LOAD:    new_row.cur = e3_item_reg.load_value;
            ACT_SAVE:    new_row.old = e3_row_reg.cur;
            ACT_RESTORE: new_row.cur = e3_row_reg.old;
            ACT_STAGE:
            begin
                if (e3_item_reg.stage > STAGE_LAST)
                begin
                    new_status = STATUS_BAD_STAGE;
                end
                else if (e3_item_reg.mass_zero)
                begin
                    new_status = STATUS_ZERO_MASS;
                end
                else
                begin
                    new_row.cur = res_val;
                    case (e3_item_reg.stage)
                        STAGE_0: new_row.w1 = res_val;
                        STAGE_1: new_row.w2 = res_val;
                        STAGE_2: new_row.w3 = res_val;
                        STAGE_3:
                        begin
                            new_row.w4 = res_val;
                            new_row.s3 = e3_s_reg;
                        end
                        default: new_row.w1 = e3_row_reg.w1;
                    endcase
                    new_status = (res_sat || e3_sflag_reg) ? STATUS_SAT : STATUS_OK;
                end
            end
            default: new_row = e3_row_reg;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "ssprk54_stage_update_core_assert.svh"

    `SSPRK54_ASSERT_NOW(a_no_rw_overlap, wr_en && d_valid_reg[DIV_STEPS-1] && !hazard, wr_idx != rd_idx)
    `SSPRK54_ASSERT_NEXT(a_sat_reported, wr_en && e3_item_reg.action == ACT_STAGE && e3_upd_ok && e3_sflag_reg, rsp.status == STATUS_SAT)
    `SSPRK54_ASSERT_NOW(a_error_keeps_row, wr_en && (new_status == STATUS_BAD_STAGE || new_status == STATUS_ZERO_MASS), new_row === e3_row_reg)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssprk54_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        time_step_wr_en;
    logic [31:0] time_step_wr_data;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;

    ssprk54_stage_update_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .time_step_wr_en   (time_step_wr_en),
        .time_step_wr_data (time_step_wr_data),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req               (req),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .rsp               (rsp)
    );

    // Predicted solver state and the flags that record which entries hold data.
    logic [31:0]        dt_model;
    logic signed [31:0] cur_val [DOF_COUNT];
    logic signed [31:0] old_val [DOF_COUNT];
    logic signed [31:0] slot_val [4][DOF_COUNT];
    logic signed [31:0] s3_val [DOF_COUNT];
    bit                 have_cur [DOF_COUNT];
    bit                 have_old [DOF_COUNT];
    bit                 have_slot [4][DOF_COUNT];
    bit                 have_s3 [DOF_COUNT];

    rsp_t expected_rsp [$];
    int   error_count;
    int   requests_sent;
    int   idle_pct;
    int   stall_pct;
    int   hold_cycles;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp_mag(bit neg, longint unsigned m,
                                                     inout bit flag);
        if (neg)
        begin
            if (m > 64'h8000_0000)
            begin
                flag = 1'b1;
                m = 64'h8000_0000;
            end
            return 32'(-longint'(m));
        end
        if (m > 64'h7FFF_FFFF)
        begin
            flag = 1'b1;
            m = 64'h7FFF_FFFF;
        end
        return 32'(m);
    endfunction

    function automatic logic signed [31:0] round_clamp(longint acc, inout bit flag);
        longint unsigned m;
        m = (acc < 0) ? longint'(-acc) : longint'(acc);
        m = (m + (64'd1 << 29)) >> 30;
        return clamp_mag(acc < 0, m, flag);
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t               o;
        logic [1:0]         st;
        bit                 flag;
        int                 i;
        longint             rr;
        longint unsigned    m;
        longint unsigned    q;
        longint             s;
        longint             acc;
        logic signed [31:0] res;
        i = r.dof_index;
        st = STATUS_OK;
        flag = 1'b0;
        case (r.action)
            ACT_LOAD:
            begin
                cur_val[i] = r.load_value;
                have_cur[i] = 1'b1;
            end
            ACT_SAVE:
            begin
                old_val[i] = cur_val[i];
                have_old[i] = 1'b1;
            end
            ACT_RESTORE:
            begin
                cur_val[i] = old_val[i];
                have_cur[i] = 1'b1;
            end
            default:
            begin
                if (r.stage > STAGE_LAST)
                    st = STATUS_BAD_STAGE;
                else if (r.mass_diag == 32'd0)
                    st = STATUS_ZERO_MASS;
                else
                begin
                    rr = r.residual;
                    m = (rr < 0) ? longint'(-rr) : longint'(rr);
                    q = (m * longint'(dt_model) + longint'(r.mass_diag >> 1))
                        / longint'(r.mass_diag);
                    s = clamp_mag(rr < 0, q, flag);
                    case (r.stage)
                        STAGE_0: acc = longint'(old_val[i]) * longint'(ONE_Q30)
                            + longint'(K_S0_R) * s;
                        STAGE_1: acc = longint'(K_S1_U0) * old_val[i]
                            + longint'(K_S1_U1) * slot_val[0][i] + longint'(K_S1_R) * s;
                        STAGE_2: acc = longint'(K_S2_U0) * old_val[i]
                            + longint'(K_S2_U2) * slot_val[1][i] + longint'(K_S2_R) * s;
                        STAGE_3: acc = longint'(K_S3_U0) * old_val[i]
                            + longint'(K_S3_U3) * slot_val[2][i] + longint'(K_S3_R) * s;
                        default: acc = longint'(K_S4_U2) * slot_val[1][i]
                            + longint'(K_S4_U3) * slot_val[2][i]
                            + longint'(K_S4_R3) * s3_val[i]
                            + longint'(K_S4_U4) * slot_val[3][i]
                            + longint'(K_S4_R4) * s;
                    endcase
                    res = round_clamp(acc, flag);
                    cur_val[i] = res;
                    have_cur[i] = 1'b1;
                    if (r.stage < STAGE_LAST)
                    begin
                        slot_val[r.stage][i] = res;
                        have_slot[r.stage][i] = 1'b1;
                    end
                    if (r.stage == STAGE_3)
                    begin
                        s3_val[i] = 32'(s);
                        have_s3[i] = 1'b1;
                    end
                end
            end
        endcase
        if (st == STATUS_OK && flag)
            st = STATUS_SAT;
        o.out_index = 12'(i);
        o.current_out = cur_val[i];
        o.status = st;
        return o;
    endfunction

    // True when the request reads only entries that have been written.
    function automatic bit reads_written(req_t r);
        int i;
        i = r.dof_index;
        case (r.action)
            ACT_LOAD: return 1'b1;
            ACT_SAVE: return have_cur[i];
            ACT_RESTORE: return have_old[i];
            default:
            begin
                if (r.stage > STAGE_LAST || r.mass_diag == 32'd0)
                    return have_cur[i];
                case (r.stage)
                    STAGE_0: return have_old[i];
                    STAGE_1: return have_old[i] && have_slot[0][i];
                    STAGE_2: return have_old[i] && have_slot[1][i];
                    STAGE_3: return have_old[i] && have_slot[2][i];
                    default: return have_slot[1][i] && have_slot[2][i]
                        && have_slot[3][i] && have_s3[i];
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    function automatic int rand_dof();
        if ($urandom_range(1))
            return $urandom_range(15);
        return DOF_COUNT - 1 - $urandom_range(15);
    endfunction

    // Builds a request with random operands; one that would read unwritten data
    // becomes a load.
    function automatic req_t make_request(int dof, logic [1:0] act, logic [2:0] stg);
        req_t r;
        r.action = act;
        r.stage = stg;
        r.dof_index = 12'(dof);
        r.load_value = rand_value();
        r.residual = rand_value();
        r.mass_diag = ($urandom_range(9) == 0) ? rand_mass() : rand_mass() | 32'd1;
        if (act == ACT_STAGE && $urandom_range(19) == 0)
            r.mass_diag = 32'd0;
        if (!reads_written(r))
            r.action = ACT_LOAD;
        return r;
    endfunction

    task automatic send_request(req_t r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp.push_back(apply_request(r));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_time_step(logic [31:0] value);
        req_valid <= 1'b0;
        wait_for_results();
        time_step_wr_en <= 1'b1;
        time_step_wr_data <= value;
        @(posedge clk);
        time_step_wr_en <= 1'b0;
        dt_model = value;
    endtask

    task automatic run_step_sequence(int dof);
        logic [2:0] k;
        send_request(make_request(dof, ACT_LOAD, STAGE_0));
        send_request(make_request(dof, ACT_SAVE, STAGE_0));
        for (k = STAGE_0; k <= STAGE_LAST; k++)
        begin
            if ($urandom_range(15) == 0)
                send_request(make_request(dof, ACT_STAGE,
                                          3'($urandom_range(STAGE_LAST + 1, 7))));
            send_request(make_request(dof, ACT_STAGE, k));
        end
        if ($urandom_range(3) == 0)
            send_request(make_request(dof, ACT_RESTORE, STAGE_0));
    endtask

    task automatic run_mixed_traffic(int count);
        int target;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            if ($urandom_range(9) < 7)
                run_step_sequence(rand_dof());
            else if ($urandom_range(3) == 0)
                send_request(make_request($urandom_range(DOF_COUNT - 1), ACT_LOAD,
                                          3'($urandom_range(7))));
            else
                send_request(make_request(rand_dof(), 2'($urandom_range(3)),
                                          3'($urandom_range(7))));
        end
    endtask

    task automatic test_directed();
        req_t r;
        logic [2:0] k;
        set_time_step(32'h0001_0000);
        r = make_request(0, ACT_LOAD, STAGE_0);
        r.load_value = 32'sh7FFF_FFFF;
        send_request(r);
        r.dof_index = 12'hFFF;
        r.load_value = 32'sh8000_0000;
        send_request(r);
        send_request(make_request(0, ACT_SAVE, STAGE_0));
        send_request(make_request(12'hFFF, ACT_SAVE, STAGE_0));
        for (k = STAGE_0; k <= STAGE_LAST; k++)
        begin
            r = make_request(12'hFFF, ACT_STAGE, k);
            r.residual = 32'sh0002_0000;
            r.mass_diag = 32'h0001_0000;
            send_request(r);
        end
        r = make_request(0, ACT_STAGE, STAGE_0);
        r.residual = 32'sh7FFF_FFFF;
        r.mass_diag = 32'd1;
        send_request(r);
        r.residual = 32'sh8000_0000;
        send_request(r);
        r.stage = 3'd7;
        send_request(r);
        r.stage = STAGE_1;
        r.mass_diag = 32'd0;
        send_request(r);
        send_request(make_request(0, ACT_RESTORE, STAGE_0));
        send_request(make_request(12'hFFF, ACT_RESTORE, STAGE_0));
    endtask

    task automatic test_no_idling();
        idle_pct = 0;
        stall_pct = 0;
        run_mixed_traffic(380);
    endtask

    task automatic test_sender_idle();
        set_time_step(32'hFFFF_FFFF);
        idle_pct = 88;
        stall_pct = 0;
        run_mixed_traffic(360);
    endtask

    task automatic test_receiver_stall();
        set_time_step(32'h0000_0000);
        idle_pct = 0;
        stall_pct = 88;
        run_mixed_traffic(360);
    endtask

    task automatic test_both_idle();
        set_time_step($urandom_range(32'h0000_0100, 32'h0004_0000));
        idle_pct = 13;
        stall_pct = 13;
        run_mixed_traffic(380);
        set_time_step($urandom);
        run_mixed_traffic(300);
    endtask

    task automatic test_backpressure();
        set_time_step(32'h0000_8000);
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 400;
        run_mixed_traffic(150);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response for dof %0d with no request outstanding", rsp.out_index);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.out_index !== want.out_index)
                begin
                    $error("out_index: expected %0d, got %0d", want.out_index, rsp.out_index);
                    error_count++;
                end
                if (rsp.current_out !== want.current_out)
                begin
                    $error("current_out: expected %0d, got %0d",
                           want.current_out, rsp.current_out);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        time_step_wr_en = 1'b0;
        time_step_wr_data = '0;
        req_valid = 1'b0;
        req = '0;
        dt_model = '0;
        error_count = 0;
        requests_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        req_valid <= 1'b0;
        wait_for_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ssprk54_pkg.sv
rtl/core/ssprk54_stage_update_core.sv
tb/sv/tb_top.sv
